// File: rtl/core/tvdi_pkg.sv
// ---------------------------------------------------------------------------
// tvdi_pkg
// Item types and controller/datapath command and status types shared by the
// triangle vertex dedup indexer.
// ---------------------------------------------------------------------------
`default_nettype none

package tvdi_pkg;

  localparam int unsigned ATTR_W      = 24;
  localparam int unsigned VERT_IDX_W  = 12;
  localparam int unsigned EPOCH_W     = 8;
  localparam int unsigned CRC_W       = 32;
  localparam int unsigned CRC_BYTES   = 16;
  localparam int unsigned NUM_CORNERS = 3;

  localparam logic [CRC_W-1:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [CRC_W-1:0] CRC_XOROUT  = 32'hFFFFFFFF;
  localparam logic [CRC_W-1:0] COLOUR_WORD = 32'hFFFFFFFF;

  typedef struct packed {
    logic              new_mesh;
    logic [ATTR_W-1:0] pos_index_a;
    logic [ATTR_W-1:0] normal_index_a;
    logic [ATTR_W-1:0] uv_index_a;
    logic [ATTR_W-1:0] pos_index_b;
    logic [ATTR_W-1:0] normal_index_b;
    logic [ATTR_W-1:0] uv_index_b;
    logic [ATTR_W-1:0] pos_index_c;
    logic [ATTR_W-1:0] normal_index_c;
    logic [ATTR_W-1:0] uv_index_c;
  } in_item_t;

  typedef struct packed {
    logic [VERT_IDX_W-1:0] vert_index;
    logic                  is_new;
    logic [ATTR_W-1:0]     out_pos_index;
    logic [ATTR_W-1:0]     out_normal_index;
    logic [ATTR_W-1:0]     out_uv_index;
    logic                  overflow;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic cap_in;
    logic mesh_start;
    logic sweep_step;
    logic crc_init;
    logic crc_step;
    logic mod_init;
    logic mod_step;
    logic probe_init;
    logic probe_rd;
    logic probe_chk;
    logic out_load;
    logic corner_next;
  } dp_cmd_t;

  typedef struct packed {
    logic new_mesh;
    logic epoch_full;
    logic sweep_last;
    logic crc_last;
    logic mod_needed;
    logic mod_last;
    logic probe_done;
    logic corner_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/tvdi_ram.sv
// ---------------------------------------------------------------------------
// tvdi_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tvdi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tvdi_ctrl.sv
// ---------------------------------------------------------------------------
// tvdi_ctrl
// Sequencer: reset sweep, mesh start, per-corner hash, bucket reduction,
// probe loop and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tvdi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  output      tvdi_pkg::dp_cmd_t cmd,
  input  wire tvdi_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MESH  = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_CRC   = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_PINIT = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_MESH;
        end
      end
      S_MESH: begin
        if (sts.new_mesh) begin
          cmd.mesh_start = 1'b1;
        end
        if (sts.new_mesh && sts.epoch_full) begin
          state_nxt = S_SWEEP;
        end else begin
          cmd.crc_init = 1'b1;
          state_nxt    = S_CRC;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.crc_init = 1'b1;
          state_nxt    = S_CRC;
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (sts.crc_last) begin
          cmd.mod_init = 1'b1;
          state_nxt    = S_MOD;
        end
      end
      S_MOD: begin
        if (!sts.mod_needed) begin
          state_nxt = S_PINIT;
        end else begin
          cmd.mod_step = 1'b1;
          if (sts.mod_last) begin
            state_nxt = S_PINIT;
          end
        end
      end
      S_PINIT: begin
        cmd.probe_init = 1'b1;
        state_nxt      = S_RD;
      end
      S_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        cmd.probe_chk = 1'b1;
        state_nxt     = sts.probe_done ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.corner_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.corner_next = 1'b1;
            cmd.crc_init    = 1'b1;
            state_nxt       = S_CRC;
          end
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/tvdi_dp.sv
// ---------------------------------------------------------------------------
// tvdi_dp
// Datapath: item capture, byte-serial hash, reciprocal bucket remainder,
// epoch-tagged slot table, probe registers and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tvdi_dp #(
  parameter int unsigned TABLE_SLOTS     = 8192,
  parameter int unsigned MAX_VERTICES    = 4096,
  parameter int unsigned ATTR_INDEX_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tvdi_pkg::in_item_t in_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      tvdi_pkg::out_item_t out_data,
  input  wire tvdi_pkg::dp_cmd_t  cmd,
  output      tvdi_pkg::dp_sts_t  sts
);

  localparam int unsigned AW  = $clog2(TABLE_SLOTS);
  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW  = tvdi_pkg::EPOCH_W;
  localparam int unsigned A   = tvdi_pkg::ATTR_W;
  localparam int unsigned KW  = 3 * A;
  localparam int unsigned DW  = EW + VW + KW;
  localparam int unsigned VIW = tvdi_pkg::VERT_IDX_W;
  localparam logic [A-1:0] AMASK =
    (ATTR_INDEX_BITS >= A) ? {A{1'b1}} : A'((64'd1 << ATTR_INDEX_BITS) - 64'd1);
  localparam logic MOD_NEEDED = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) != 0);
  localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_SLOTS - 1);
  localparam logic [AW:0]   SLOTS_W   = (AW + 1)'(TABLE_SLOTS);
  localparam logic [31:0]   SLOTS32   = 32'(TABLE_SLOTS);
  localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
  localparam logic [CW-1:0] MAXV      = CW'(MAX_VERTICES);
  localparam logic [1:0]    CORNER_LAST = 2'(tvdi_pkg::NUM_CORNERS - 1);
  localparam logic [3:0]    BYTE_LAST   = 4'(tvdi_pkg::CRC_BYTES - 1);
  localparam logic [1:0]    MOD_STEP_LAST = 2'd2;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ tvdi_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  tvdi_pkg::in_item_t  in_r;
  tvdi_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                rw_r;
  logic [EW-1:0]       epoch_r;
  logic [CW-1:0]       vcount_r;
  logic [AW-1:0]       sweep_r;
  logic [31:0]         crc_r;
  logic [3:0]          bidx_r;
  logic [AW-1:0]       rem_r;
  logic [1:0]          mstep_r;
  logic [31:0]         q_r;
  logic [AW:0]         r_r;
  logic [AW-1:0]       slot_r;
  logic [AW-1:0]       nprobe_r;
  logic [1:0]          corner_r;
  logic [VW-1:0]       res_vert_r;
  logic                res_new_r;
  logic                res_ovf_r;

  // current corner key, winding applied
  logic [1:0]   csel;
  logic [A-1:0] k_pos, k_nrm, k_uv;
  logic [KW-1:0] key;

  always_comb begin
    csel = rw_r ? (2'd2 - corner_r) : corner_r;
    unique case (csel)
      2'd0: begin
        k_pos = in_r.pos_index_a; k_nrm = in_r.normal_index_a; k_uv = in_r.uv_index_a;
      end
      2'd1: begin
        k_pos = in_r.pos_index_b; k_nrm = in_r.normal_index_b; k_uv = in_r.uv_index_b;
      end
      default: begin
        k_pos = in_r.pos_index_c; k_nrm = in_r.normal_index_c; k_uv = in_r.uv_index_c;
      end
    endcase
    k_pos = k_pos & AMASK;
    k_nrm = k_nrm & AMASK;
    k_uv  = k_uv & AMASK;
    key   = {k_pos, k_nrm, k_uv};
  end

  // hash bytes: pos, normal, uv, colour word, each little-endian
  logic [127:0] hash_msg;
  logic [7:0]   hash_byte;
  logic [31:0]  crc_fin;
  logic [63:0]  prod;
  logic [31:0]  qs;
  logic [31:0]  rdiff;
  logic [AW:0]  rem_fix;
  logic [AW-1:0] bucket;

  assign hash_msg  = {tvdi_pkg::COLOUR_WORD, 8'd0, k_uv, 8'd0, k_nrm, 8'd0, k_pos};
  assign hash_byte = hash_msg[{bidx_r, 3'b000} +: 8];
  assign crc_fin   = crc_r ^ tvdi_pkg::CRC_XOROUT;
  // quotient estimate is low by at most one, so one compare and subtract ends it
  assign prod      = 64'(crc_fin) * 64'(RECIP);
  assign qs        = q_r * SLOTS32;
  assign rdiff     = crc_fin - qs;
  assign rem_fix   = (r_r >= SLOTS_W) ? (r_r - SLOTS_W) : r_r;
  assign bucket    = MOD_NEEDED ? rem_r : crc_fin[AW-1:0];

  // slot table: {epoch, vertex, key}; an entry is live when its epoch matches
  logic [DW-1:0] rd_data;
  logic [DW-1:0] wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [EW-1:0] ent_epoch;
  logic [VW-1:0] ent_vert;
  logic [KW-1:0] ent_key;
  logic          ent_empty;
  logic          ent_match;
  logic          room;
  logic          insert;
  logic          sweeping;

  assign ent_epoch = rd_data[DW-1 -: EW];
  assign ent_vert  = rd_data[KW +: VW];
  assign ent_key   = rd_data[KW-1:0];
  assign ent_empty = (ent_epoch != epoch_r);
  assign ent_match = !ent_empty && (ent_key == key);
  assign room      = (vcount_r < MAXV);
  assign insert    = cmd.probe_chk && ent_empty && room;
  assign sweeping  = cmd.sweep_step;

  always_comb begin
    wr_en   = sweeping || insert;
    wr_addr = sweeping ? sweep_r : slot_r;
    wr_data = sweeping ? '0 : {epoch_r, vcount_r[VW-1:0], key};
  end

  tvdi_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.probe_rd),
    .raddr (slot_r),
    .rdata (rd_data)
  );

  logic probe_done;
  assign probe_done = ent_empty || ent_match || (nprobe_r == SLOT_LAST);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rw_r     <= 1'b0;
      epoch_r  <= EW'(1);
      vcount_r <= '0;
      sweep_r  <= '0;
      corner_r <= '0;
      bidx_r   <= '0;
      mstep_r  <= '0;
      nprobe_r <= '0;
    end else begin
      if (cfg_we) begin
        rw_r <= cfg_wdata;
      end
      if (cmd.mesh_start) begin
        vcount_r <= '0;
        epoch_r  <= (epoch_r == {EW{1'b1}}) ? EW'(1) : epoch_r + EW'(1);
      end else if (insert) begin
        vcount_r <= vcount_r + CW'(1);
      end
      if (sweeping) begin
        sweep_r <= (sweep_r == SLOT_LAST) ? '0 : sweep_r + AW'(1);
      end
      if (cmd.cap_in) begin
        corner_r <= '0;
      end else if (cmd.corner_next) begin
        corner_r <= corner_r + 2'd1;
      end
      if (cmd.crc_init) begin
        bidx_r <= '0;
      end else if (cmd.crc_step) begin
        bidx_r <= bidx_r + 4'd1;
      end
      if (cmd.mod_init) begin
        mstep_r <= '0;
      end else if (cmd.mod_step) begin
        mstep_r <= mstep_r + 2'd1;
      end
      if (cmd.probe_init) begin
        nprobe_r <= '0;
      end else if (cmd.probe_chk && !probe_done) begin
        nprobe_r <= nprobe_r + AW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_data;
    end
    if (cmd.crc_init) begin
      crc_r <= tvdi_pkg::CRC_INIT;
    end else if (cmd.crc_step) begin
      crc_r <= crc_byte(crc_r, hash_byte);
    end
    // remainder in three steps: quotient estimate, difference, correction
    if (cmd.mod_init) begin
      rem_r <= '0;
    end else if (cmd.mod_step) begin
      unique case (mstep_r)
        2'd0: begin
          q_r <= prod[63:32];
        end
        2'd1: begin
          r_r <= rdiff[AW:0];
        end
        default: begin
          rem_r <= rem_fix[AW-1:0];
        end
      endcase
    end
    if (cmd.probe_init) begin
      slot_r <= bucket;
    end else if (cmd.probe_chk && !probe_done) begin
      slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + AW'(1);
    end
    if (cmd.probe_chk && probe_done) begin
      if (ent_empty) begin
        res_vert_r <= room ? vcount_r[VW-1:0] : '0;
        res_new_r  <= room;
        res_ovf_r  <= !room;
      end else if (ent_match) begin
        res_vert_r <= ent_vert;
        res_new_r  <= 1'b0;
        res_ovf_r  <= 1'b0;
      end else begin
        res_vert_r <= '0;
        res_new_r  <= 1'b0;
        res_ovf_r  <= 1'b1;
      end
    end
  end

  // output register
  logic [VW+VIW-1:0] vert_ext;
  assign vert_ext = {{VIW{1'b0}}, res_vert_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.vert_index       <= vert_ext[VIW-1:0];
      out_r.is_new           <= res_new_r;
      out_r.out_pos_index    <= k_pos;
      out_r.out_normal_index <= k_nrm;
      out_r.out_uv_index     <= k_uv;
      out_r.overflow         <= res_ovf_r;
      out_r.last             <= (corner_r == CORNER_LAST);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.new_mesh    = in_r.new_mesh;
    sts.epoch_full  = (epoch_r == {EW{1'b1}});
    sts.sweep_last  = (sweep_r == SLOT_LAST);
    sts.crc_last    = (bidx_r == BYTE_LAST);
    sts.mod_needed  = MOD_NEEDED;
    sts.mod_last    = (mstep_r == MOD_STEP_LAST);
    sts.probe_done  = probe_done;
    sts.corner_last = (corner_r == CORNER_LAST);
    sts.out_free    = !out_valid_r || !out_stall;
  end

endmodule

`default_nettype wire

// File: rtl/core/triangle_vertex_dedup_indexer_core.sv
// ---------------------------------------------------------------------------
// triangle_vertex_dedup_indexer_core
// Hashes each triangle corner into an epoch-tagged slot table and returns a
// unique vertex index per corner, three results per triangle.
// ---------------------------------------------------------------------------
//  port group | dir | handshake         | payload
//  in_        | in  | in_valid/in_stall | tvdi_pkg::in_item_t, one triangle
//  out_       | out | out_valid/out_stall | tvdi_pkg::out_item_t, one corner
//  cfg_       | in  | cfg_we            | cfg_wdata = reverse winding
//
// each corner takes the byte-serial hash over 16 bytes, the bucket remainder by
// reciprocal multiply when the table is not a power of two, and a read and a
// check per probe through the table ram read port.
// after reset a sweep over all TABLE_SLOTS entries clears the table before in_stall
// drops; the same sweep runs on every 255th new mesh when the epoch tag wraps.
// out_stall holds the output register; the next corner is computed behind it.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_vertex_dedup_indexer_core #(
  parameter int unsigned TABLE_SLOTS     = 8192,
  parameter int unsigned MAX_VERTICES    = 4096,
  parameter int unsigned ATTR_INDEX_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire tvdi_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      tvdi_pkg::out_item_t out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  tvdi_pkg::dp_cmd_t cmd;
  tvdi_pkg::dp_sts_t sts;

  tvdi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  tvdi_dp #(
    .TABLE_SLOTS     (TABLE_SLOTS),
    .MAX_VERTICES    (MAX_VERTICES),
    .ATTR_INDEX_BITS (ATTR_INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire
